// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
// Both macros expect clk and rst_n in the scope of the use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lir_pkg.sv =====
// ----------------------------------------------------------------------------
// lir_pkg
// Shared widths, defaults, register indexes and control structs of the
// linear interpolation resampler.
// ----------------------------------------------------------------------------
package lir_pkg;

    localparam int CHANNELS_DEF  = 2;
    localparam int FRAC_BITS_DEF = 13;
    localparam int MAX_RUN_DEF   = 64;

    localparam int SAMPLE_W = 24;
    localparam int STEP_W   = 17;
    localparam int ACC_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int POS_W    = 18;

    localparam int GAIN_FRAC_BITS = 12;
    localparam int ROUND_HALF     = 2048;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_REMAINDER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_DENOMINATOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN             = 2'd3;

    localparam logic [STEP_W-1:0] STEP_RESET  = 17'd8192;
    localparam logic [ACC_W-1:0]  REM_RESET   = 16'd0;
    localparam logic [ACC_W-1:0]  DEN_RESET   = 16'd1;
    localparam logic [GAIN_W-1:0] GAIN_RESET  = 16'd4096;

    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic [ACC_W-1:0]  rate_remainder;
        logic [ACC_W-1:0]  rate_denominator;
        logic [GAIN_W-1:0] gain;
    } lir_cfg_t;

    typedef struct packed {
        logic load_in;
        logic mul1;
        logic mul2;
        logic push;
        logic final_run;
        logic end_frame;
    } lir_cmd_t;

    typedef struct packed {
        logic pos_below_one;
        logic out_free;
    } lir_sts_t;

endpackage

// ===== src/lir_in_if.sv =====
// ----------------------------------------------------------------------------
// lir_in_if
// Source frame channel: valid/ready with one stereo frame per request.
// ----------------------------------------------------------------------------
interface lir_in_if import lir_pkg::*;;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;

    modport source (output valid, output sample_left, output sample_right, input ready);
    modport sink   (input valid, input sample_left, input sample_right, output ready);

endinterface

// ===== src/lir_out_if.sv =====
// ----------------------------------------------------------------------------
// lir_out_if
// Result channel: valid/ready with one interpolated stereo sample per request.
// ----------------------------------------------------------------------------
interface lir_out_if import lir_pkg::*;;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last;

    modport source (output valid, output out_left, output out_right, output last,
                    input ready);
    modport sink   (input valid, input out_left, input out_right, input last,
                    output ready);

endinterface

// ===== src/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter with rate remainder and gain.
// ----------------------------------------------------------------------------
// Use:
//   in_ch takes one stereo source frame per request; out_ch returns zero or
//   more interpolated samples per frame, the final one marked by last.
//   cfg_we/cfg_index/cfg_data write step_size, rate_remainder,
//   rate_denominator and gain; write them only while the block is idle.
// Timing:
//   Each emitted sample passes a four-step sequence (check, interpolation
//   multiply, gain multiply, output load) that is set by the two
//   multipliers in series on each channel lane. The first sample of a frame
//   appears once it has passed these steps after the frame is taken.
//   in_ch.ready is high only while no frame is being worked on.
// Reset:
//   Clears the previous frame, position and remainder accumulator and loads
//   the register defaults (unity step, no remainder, unity gain).
// Stall:
//   A held output sample stays in the output register; the sequencer waits
//   with the next sample until it has been taken. After the final sample is
//   loaded the next frame may be taken while that sample still waits.
// ----------------------------------------------------------------------------
module linear_interp_resampler import lir_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int MAX_RUN   = MAX_RUN_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    lir_in_if.sink                in_ch,
    lir_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    lir_cfg_t cfg;
    lir_cmd_t cmd;
    lir_sts_t sts;

    lir_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lir_ctrl #(
        .MAX_RUN (MAX_RUN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lir_dp #(
        .CHANNELS  (CHANNELS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .sample_left  (in_ch.sample_left),
        .sample_right (in_ch.sample_right),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_left     (out_ch.out_left),
        .out_right    (out_ch.out_right),
        .last         (out_ch.last)
    );

endmodule

// ===== src/lir_cfg.sv =====
// ----------------------------------------------------------------------------
// lir_cfg
// Configuration register file: step, rate remainder, denominator and gain.
// ----------------------------------------------------------------------------
module lir_cfg import lir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output lir_cfg_t              cfg
);

    lir_cfg_t cfg_reg;
    lir_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SIZE:        cfg_next.step_size        = cfg_data[STEP_W-1:0];
                REG_RATE_REMAINDER:   cfg_next.rate_remainder   = cfg_data[ACC_W-1:0];
                REG_RATE_DENOMINATOR: cfg_next.rate_denominator = cfg_data[ACC_W-1:0];
                REG_GAIN:             cfg_next.gain             = cfg_data[GAIN_W-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size        <= STEP_RESET;
            cfg_reg.rate_remainder   <= REM_RESET;
            cfg_reg.rate_denominator <= DEN_RESET;
            cfg_reg.gain             <= GAIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lir_ctrl.sv =====
// ----------------------------------------------------------------------------
// lir_ctrl
// Sequencer: takes a frame, walks the emit loop one output at a time and
// closes the frame when the position reaches one frame or the run is full.
// ----------------------------------------------------------------------------
module lir_ctrl import lir_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lir_sts_t sts,
    output lir_cmd_t cmd
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_PUSH = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.pos_below_one && (cnt_reg != CNT_W'(MAX_RUN)))
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    cmd.end_frame = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                cmd.final_run = (cnt_reg == CNT_W'(MAX_RUN - 1));
                // hold until the output register can take the sample
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== src/lir_dp.sv =====
// ----------------------------------------------------------------------------
// lir_dp
// Datapath: frame and position state, interpolation multiply, gain multiply,
// rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module lir_dp import lir_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lir_cfg_t                   cfg,
    input  lir_cmd_t                   cmd,
    output lir_sts_t                   sts,
    input  logic signed [SAMPLE_W-1:0] sample_left,
    input  logic signed [SAMPLE_W-1:0] sample_right,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] out_left,
    output logic signed [SAMPLE_W-1:0] out_right,
    output logic                       last
);

    localparam int DIFF_W  = SAMPLE_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
    localparam int SCALE_W = DIFF_W + GAIN_W + 1;
    localparam int SHIFT_W = SCALE_W - GAIN_FRAC_BITS;
    localparam logic [POS_W-1:0] FRAME_UNIT = POS_W'(2 ** FRAC_BITS);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_adv_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_adv_reg;

    logic [ACC_W:0]     acc_sum;
    logic               carry;
    logic [ACC_W:0]     acc_wrap;
    logic [POS_W-1:0]   pos_sum;
    logic [FRAC_BITS-1:0] frac;
    logic               muted;

    logic                       out_valid_reg;
    logic                       last_reg;
    logic signed [SAMPLE_W-1:0] out_left_reg;
    logic signed [SAMPLE_W-1:0] out_right_reg;

    logic signed [SAMPLE_W-1:0] in_smp [CHANNELS];
    logic signed [SAMPLE_W-1:0] res    [CHANNELS];

    assign muted = (cfg.gain == '0);
    assign frac  = pos_reg[FRAC_BITS-1:0];

    // remainder accumulator: at most one carry per output
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, cfg.rate_remainder};
    assign carry    = (acc_sum >= {1'b0, cfg.rate_denominator});
    assign acc_wrap = carry ? (acc_sum - {1'b0, cfg.rate_denominator}) : acc_sum;
    assign pos_sum  = pos_reg + POS_W'(cfg.step_size) + POS_W'(carry);

    assign sts.pos_below_one = (pos_reg < FRAME_UNIT);
    assign sts.out_free      = !out_valid_reg || out_ready;

    assign in_smp[0] = sample_left;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        logic signed [SAMPLE_W-1:0] new_reg;
        logic signed [SAMPLE_W-1:0] prev_reg;
        logic signed [PROD_W-1:0]   prod_reg;
        logic signed [PROD_W-1:0]   prod_next;
        logic signed [SCALE_W-1:0]  scale_reg;
        logic signed [SCALE_W-1:0]  scale_next;
        logic signed [DIFF_W-1:0]   diff;
        logic signed [DIFF_W-1:0]   interp;
        logic        [SCALE_W-1:0]  rounded;
        logic        [SHIFT_W-1:0]  shifted;
        logic signed [SAMPLE_W-1:0] sat;

        assign diff      = $signed({new_reg[SAMPLE_W-1], new_reg})
                         - $signed({prev_reg[SAMPLE_W-1], prev_reg});
        assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, frac}));

        // floor shift: the upper product bits already round towards minus infinity
        assign interp     = $signed({prev_reg[SAMPLE_W-1], prev_reg})
                          + $signed(prod_reg[FRAC_BITS +: DIFF_W]);
        assign scale_next = SCALE_W'(interp) * SCALE_W'($signed({1'b0, cfg.gain}));

        assign rounded = scale_reg + SCALE_W'(ROUND_HALF);
        assign shifted = rounded[SCALE_W-1:GAIN_FRAC_BITS];

        always_comb
        begin
            if (!shifted[SHIFT_W-1] && (shifted[SHIFT_W-2:SAMPLE_W-1] != '0))
            begin
                sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end
            else if (shifted[SHIFT_W-1] && (shifted[SHIFT_W-2:SAMPLE_W-1] != '1))
            begin
                sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end
            else
            begin
                sat = $signed(shifted[SAMPLE_W-1:0]);
            end
        end

        assign res[c] = muted ? '0 : sat;

        always_ff @(posedge clk)
        begin
            if (cmd.load_in)
            begin
                new_reg <= in_smp[c];
            end
            if (cmd.mul1)
            begin
                prod_reg <= prod_next;
            end
            if (cmd.mul2)
            begin
                scale_reg <= scale_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                prev_reg <= '0;
            end
            else if (cmd.end_frame)
            begin
                // store silence while muted
                prev_reg <= muted ? '0 : new_reg;
            end
        end
    end

    if (CHANNELS > 1)
    begin : g_stereo
        assign in_smp[1] = sample_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            acc_reg <= '0;
        end
        else if (cmd.push)
        begin
            pos_reg <= pos_adv_reg;
            acc_reg <= acc_adv_reg;
        end
        else if (cmd.end_frame)
        begin
            pos_reg <= (pos_reg >= FRAME_UNIT) ? (pos_reg - FRAME_UNIT) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            pos_adv_reg <= pos_sum;
            acc_adv_reg <= acc_wrap[ACC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_left_reg <= res[0];
            out_right_reg <= res[CHANNELS-1];
            last_reg      <= cmd.final_run || (pos_adv_reg >= FRAME_UNIT);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign last      = last_reg;

endmodule

// ===== src/lir_checker.sv =====
// ----------------------------------------------------------------------------
// lir_checker
// Port-level checks of the resampler: output hold, busy after a frame is taken,
// no early first sample and the per-frame run limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lir_checker import lir_pkg::*;
#(
    parameter int MAX_RUN = MAX_RUN_DEF
)
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [SAMPLE_W-1:0] out_left,
    input logic signed [SAMPLE_W-1:0] out_right,
    input logic                       out_last
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);

    logic [CNT_W-1:0] run_cnt_reg;
    logic [CNT_W-1:0] run_cnt_next;

    // count samples taken since the last final sample
    always_comb
    begin
        run_cnt_next = run_cnt_reg;
        if (out_valid && out_ready)
        begin
            run_cnt_next = out_last ? '0 : (run_cnt_reg + CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else
        begin
            run_cnt_reg <= run_cnt_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_left) && $stable(out_right) && $stable(out_last), "stalled output sample changed")
    `ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "frame taken while busy")
    `ASSERT_NEXT(a_no_early_out, in_valid && in_ready, !$rose(out_valid), "output too soon after frame")
    `ASSERT_SAME(a_run_limit, out_valid && out_ready && !out_last, run_cnt_reg < CNT_W'(MAX_RUN - 1), "run limit exceeded without last")

endmodule

bind linear_interp_resampler lir_checker #(
    .MAX_RUN (MAX_RUN)
) u_lir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_left  (out_ch.out_left),
    .out_right (out_ch.out_right),
    .out_last  (out_ch.last)
);
